// File: src/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg: shared types and constants for the two-link arm solver
// Fixed-point widths, CORDIC arctangent table, cell payload structs and
// small helper functions used by the top level and its cells.
// ----------------------------------------------------------------------------
package tlik_pkg;

  // CORDIC depth; the arctangent table ends at 24 entries
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int NSTG          = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  // datapath widths
  localparam int CW        = 52;  // CORDIC x/y width, covers Q8.38 plus gain growth
  localparam int DIV_STEPS = 31;  // quotient bits of the Q2.30 cosine
  localparam int REM_W     = 35;
  localparam int DEN_W     = 34;
  localparam int SQ_STEPS  = 31;  // result bits of the Q2.30 sine
  localparam int SQ_W      = 62;
  localparam int SV_W      = 61;

  // end-to-end pipeline depth in cycles
  localparam int LAT = 3 + DIV_STEPS + 3 + SQ_STEPS + 2 + NSTG + 2 + NSTG + 1;

  // constants
  localparam logic [31:0] QUARTER   = 32'h4000_0000;
  localparam logic [31:0] HALF      = 32'h8000_0000;
  localparam logic [31:0] THREE_Q   = 32'hC000_0000;
  localparam logic [29:0] INV_GAIN  = 30'd652032875;
  localparam logic [15:0] UPPER_RST = 16'd3840;
  localparam logic [15:0] LOWER_RST = 16'd6400;

  // register indexes
  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;

  // cosine classification
  localparam logic [1:0] CLS_MID  = 2'd0;
  localparam logic [1:0] CLS_NEAR = 2'd1;
  localparam logic [1:0] CLS_FAR  = 2'd2;
  localparam logic [1:0] CLS_ZERO = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } rot_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [30:0]      q;
  } div_t;

  typedef struct packed {
    logic [SV_W-1:0] v;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // vectoring entry: fold left half-plane into the right one
  function automatic vec_t vec_prep(input logic signed [CW-1:0] y,
                                    input logic signed [CW-1:0] x);
    vec_t r;
    r.zero = (x == '0) && (y == '0);
    r.x    = x;
    r.y    = y;
    r.z    = '0;
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        r.x = y;
        r.y = -x;
        r.z = QUARTER;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -QUARTER;
      end
    end
    return r;
  endfunction

  // binary angle rounded to 16 bits
  function automatic logic [15:0] angle_out(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h0000_8000;
    return t[31:16];
  endfunction

  // Q8.38 to Q8.8, round half up, saturate
  function automatic logic [15:0] sat_q88(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    logic [15:0]          o;
    t = v + (CW'(1) << 29);
    r = t >>> 30;
    if (r > $signed(CW'(32767))) begin
      o = 16'h7FFF;
    end else if (r < $signed(CW'(-32768))) begin
      o = 16'h8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

endpackage

// File: src/two_link_planar_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// two_link_planar_inverse_kinematics: joint angles for a planar two-link arm
// Law-of-cosines solver with divider, square root and CORDIC cell chains.
// ----------------------------------------------------------------------------
// Usage: one target request is taken every cycle and each one yields one
// result request. The stages are: 3 setup stages, a 31-cell divider for the
// Q2.30 cosine, 3 stages of clamp, square and subtract, a 31-cell square root
// for the sine, 2 product and fold stages, three parallel vectoring chains of
// CORDIC_STAGES cells, 2 stages of angle difference and fold, a rotation chain
// of CORDIC_STAGES cells for the elbow point, and the output register. The
// whole pipeline advances as one; it holds only while a finished result is
// stalled. Link lengths are written through cfg_write/cfg_index/cfg_data; the
// user must do so only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module two_link_planar_inverse_kinematics (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] shoulder_angle,
  output logic signed [15:0] elbow_angle,
  output logic signed [15:0] elbow_x,
  output logic signed [15:0] elbow_y,
  output logic               unreachable,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import tlik_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [1:0]         cls;
    logic               neg;
    logic               un;
  } side1_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [31:0] c;
    logic               un;
  } side2_t;

  typedef struct packed {
    logic [31:0] q1;
    logic [31:0] q2;
    logic        un;
  } side4_t;

  logic [15:0]    l1;
  logic [15:0]    l2;
  logic           en;
  logic [LAT-1:0] vld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= UPPER_RST;
      l2 <= LOWER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_UPPER: l1 <= cfg_data;
        REG_LOWER: l2 <= cfg_data;
      endcase
    end
  end

  // global advance: hold only while the output is full and stalled
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage A: squares and link products
  logic signed [31:0] xx_w, yy_w;
  logic [31:0]        l11_w, l22_w, l12_w;
  logic [16:0]        lsum_w;
  logic [33:0]        lsum2_w;
  logic [30:0]        a_xx, a_yy;
  logic [31:0]        a_l11, a_l22, a_l12;
  logic [33:0]        a_lsum2;
  logic signed [15:0] a_x, a_y;

  assign xx_w    = target_x * target_x;
  assign yy_w    = target_y * target_y;
  assign l11_w   = l1 * l1;
  assign l22_w   = l2 * l2;
  assign l12_w   = l1 * l2;
  assign lsum_w  = {1'b0, l1} + {1'b0, l2};
  assign lsum2_w = lsum_w * lsum_w;

  always_ff @(posedge clk) begin
    if (en) begin
      a_xx    <= xx_w[30:0];
      a_yy    <= yy_w[30:0];
      a_l11   <= l11_w;
      a_l22   <= l22_w;
      a_l12   <= l12_w;
      a_lsum2 <= lsum2_w;
      a_x     <= target_x;
      a_y     <= target_y;
    end
  end

  // stage B: radius squared, numerator and denominator of the cosine
  logic [31:0]        r2_w;
  logic signed [34:0] num_w;
  logic [31:0]        b_r2;
  logic signed [34:0] b_num;
  logic [33:0]        b_den;
  logic [33:0]        b_lsum2;
  logic signed [15:0] b_x, b_y;

  assign r2_w  = {1'b0, a_xx} + {1'b0, a_yy};
  assign num_w = $signed({3'b000, a_l11} + {3'b000, a_l22} - {3'b000, r2_w});

  always_ff @(posedge clk) begin
    if (en) begin
      b_r2    <= r2_w;
      b_num   <= num_w;
      b_den   <= {a_l12, 1'b0};
      b_lsum2 <= a_lsum2;
      b_x     <= a_x;
      b_y     <= a_y;
    end
  end

  // stage C: classify reach and load the divider
  div_t               dc [DIV_STEPS+1];
  side1_t             s1 [DIV_STEPS+1];
  logic signed [34:0] dens_w;
  logic [1:0]         cls_w;
  logic               un_w;
  logic [34:0]        mag_w;

  always_comb begin
    dens_w = $signed({1'b0, b_den});
    mag_w  = b_num[34] ? 35'(-b_num) : b_num;
    priority if (b_den == '0) begin
      cls_w = CLS_ZERO;
      un_w  = {2'b00, b_r2} != b_lsum2;
    end else if (b_num > dens_w) begin
      cls_w = CLS_NEAR;
      un_w  = 1'b1;
    end else if (b_num < -dens_w) begin
      cls_w = CLS_FAR;
      un_w  = 1'b1;
    end else begin
      cls_w = CLS_MID;
      un_w  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc[0].rem <= mag_w;
      dc[0].den <= b_den;
      dc[0].q   <= '0;
      s1[0].x   <= b_x;
      s1[0].y   <= b_y;
      s1[0].cls <= cls_w;
      s1[0].neg <= b_num[34];
      s1[0].un  <= un_w;
    end
  end

  // divider chain
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    tlik_div_cell u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (dc[j]),
      .d_out (dc[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        s1[j+1] <= s1[j];
      end
    end
  end

  // stage D: signed, clamped cosine
  logic [30:0]        q_w;
  logic signed [31:0] c_w;
  logic [30:0]        cmag_w;
  side2_t             d_side;
  logic [30:0]        d_cmag;

  assign q_w = dc[DIV_STEPS].q;

  always_comb begin
    unique case (s1[DIV_STEPS].cls)
      CLS_MID: begin
        c_w    = s1[DIV_STEPS].neg ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});
        cmag_w = q_w;
      end
      CLS_NEAR: begin
        c_w    = $signed(QUARTER);
        cmag_w = QUARTER[30:0];
      end
      default: begin
        c_w    = $signed(THREE_Q);
        cmag_w = QUARTER[30:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side.x  <= s1[DIV_STEPS].x;
      d_side.y  <= s1[DIV_STEPS].y;
      d_side.c  <= c_w;
      d_side.un <= s1[DIV_STEPS].un;
      d_cmag    <= cmag_w;
    end
  end

  // stage E: cosine squared
  logic [61:0] csq_w;
  logic [61:0] e_csq;
  side2_t      e_side;

  assign csq_w = d_cmag * d_cmag;

  always_ff @(posedge clk) begin
    if (en) begin
      e_csq  <= csq_w;
      e_side <= d_side;
    end
  end

  // stage F: 1 - c^2 into the square root
  sqrt_t       sq [SQ_STEPS+1];
  side2_t      s2 [SQ_STEPS+1];
  logic [61:0] one_minus_w;

  assign one_minus_w = (62'(1) << 60) - e_csq;

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].v   <= one_minus_w[SV_W-1:0];
      sq[0].res <= '0;
      s2[0]     <= e_side;
    end
  end

  // square root chain, MSB digit first
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    tlik_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (5'(SQ_STEPS - 1 - j)),
      .d_in  (sq[j]),
      .d_out (sq[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        s2[j+1] <= s2[j];
      end
    end
  end

  // stage G: lower-link products
  logic [30:0]        s_w;
  logic [46:0]        l2s_w;
  logic signed [48:0] l2c_w;
  logic [30:0]        g_s;
  logic [46:0]        g_l2s;
  logic signed [48:0] g_l2c;
  side2_t             g_side;

  assign s_w   = sq[SQ_STEPS].res[30:0];
  assign l2s_w = l2 * s_w;
  assign l2c_w = $signed({1'b0, l2}) * s2[SQ_STEPS].c;

  always_ff @(posedge clk) begin
    if (en) begin
      g_s    <= s_w;
      g_l2s  <= l2s_w;
      g_l2c  <= l2c_w;
      g_side <= s2[SQ_STEPS];
    end
  end

  // stage H: three vectoring inputs
  vec_t                 vc0 [NSTG+1];
  vec_t                 vc1 [NSTG+1];
  vec_t                 vc2 [NSTG+1];
  logic                 u3  [NSTG+1];
  logic signed [CW-1:0] y0_w, x0_w, y1_w, x1_w, y2_w, x2_w;

  always_comb begin
    y0_w = $signed({{(CW-31){1'b0}}, g_s});
    x0_w = -$signed({{(CW-32){g_side.c[31]}}, g_side.c});
    y1_w = $signed({{(CW-40){g_side.y[15]}}, g_side.y, 24'd0});
    x1_w = $signed({{(CW-40){g_side.x[15]}}, g_side.x, 24'd0});
    y2_w = $signed({{(CW-47){1'b0}}, g_l2s});
    x2_w = $signed({{(CW-46){1'b0}}, l1, 30'd0})
         - $signed({{(CW-49){g_l2c[48]}}, g_l2c});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vc0[0] <= vec_prep(y0_w, x0_w);
      vc1[0] <= vec_prep(y1_w, x1_w);
      vc2[0] <= vec_prep(y2_w, x2_w);
      u3[0]  <= g_side.un;
    end
  end

  // vectoring chains: elbow angle, target bearing, link offset
  for (genvar j = 0; j < NSTG; j++) begin : g_vec
    tlik_vec_cell u_lane0 (
      .clk   (clk),
      .en    (en),
      .idx   (5'(j)),
      .d_in  (vc0[j]),
      .d_out (vc0[j+1])
    );
    tlik_vec_cell u_lane1 (
      .clk   (clk),
      .en    (en),
      .idx   (5'(j)),
      .d_in  (vc1[j]),
      .d_out (vc1[j+1])
    );
    tlik_vec_cell u_lane2 (
      .clk   (clk),
      .en    (en),
      .idx   (5'(j)),
      .d_in  (vc2[j]),
      .d_out (vc2[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        u3[j+1] <= u3[j];
      end
    end
  end

  // stage I: joint angles, scaled upper link
  logic [31:0] a0_w, a1_w, a2_w;
  logic [45:0] l1inv_w;
  logic [31:0] i_q1, i_q2;
  logic [45:0] i_l1inv;
  logic        i_un;

  assign a0_w    = vc0[NSTG].zero ? 32'd0 : vc0[NSTG].z;
  assign a1_w    = vc1[NSTG].zero ? 32'd0 : vc1[NSTG].z;
  assign a2_w    = vc2[NSTG].zero ? 32'd0 : vc2[NSTG].z;
  assign l1inv_w = l1 * INV_GAIN;

  always_ff @(posedge clk) begin
    if (en) begin
      i_q1    <= a1_w - a2_w;
      i_q2    <= a0_w;
      i_l1inv <= l1inv_w;
      i_un    <= u3[NSTG];
    end
  end

  // stage J: rotation entry with quarter-turn fold
  rot_t                 rc [NSTG+1];
  side4_t               s4 [NSTG+1];
  rot_t                 rp_w;
  logic signed [CW-1:0] ex_w;

  always_comb begin
    ex_w    = $signed({{(CW-46){1'b0}}, i_l1inv});
    rp_w.x  = ex_w;
    rp_w.y  = '0;
    rp_w.z  = i_q1;
    if (i_q1 > QUARTER && i_q1 < THREE_Q) begin
      rp_w.x = '0;
      if (i_q1 < HALF) begin
        rp_w.y = ex_w;
        rp_w.z = i_q1 - QUARTER;
      end else begin
        rp_w.y = -ex_w;
        rp_w.z = i_q1 + QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc[0]    <= rp_w;
      s4[0].q1 <= i_q1;
      s4[0].q2 <= i_q2;
      s4[0].un <= i_un;
    end
  end

  // rotation chain for the elbow point
  for (genvar j = 0; j < NSTG; j++) begin : g_rot
    tlik_rot_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (5'(j)),
      .d_in  (rc[j]),
      .d_out (rc[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        s4[j+1] <= s4[j];
      end
    end
  end

  // stage K: output register
  always_ff @(posedge clk) begin
    if (en) begin
      shoulder_angle <= angle_out(s4[NSTG].q1);
      elbow_angle    <= angle_out(s4[NSTG].q2);
      elbow_x        <= sat_q88(rc[NSTG].x);
      elbow_y        <= sat_q88(rc[NSTG].y);
      unreachable    <= s4[NSTG].un;
    end
  end

endmodule

// File: src/tlik_div_cell.sv
// ----------------------------------------------------------------------------
// tlik_div_cell: one restoring-division step
// Produces one quotient bit and passes the doubled remainder on.
// ----------------------------------------------------------------------------
module tlik_div_cell (
  input  logic          clk,
  input  logic          en,
  input  tlik_pkg::div_t d_in,
  output tlik_pkg::div_t d_out
);
  import tlik_pkg::*;

  logic             ge;
  logic [REM_W-1:0] diff;

  // compare and conditional subtract
  always_comb begin
    ge   = d_in.rem >= {1'b0, d_in.den};
    diff = ge ? d_in.rem - {1'b0, d_in.den} : d_in.rem;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rem <= {diff[REM_W-2:0], 1'b0};
      d_out.den <= d_in.den;
      d_out.q   <= {d_in.q[29:0], ge};
    end
  end

endmodule

// File: src/tlik_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tlik_sqrt_cell: one digit of the bitwise integer square root
// idx selects the trial bit 4^idx for this position in the chain.
// ----------------------------------------------------------------------------
module tlik_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     idx,
  input  tlik_pkg::sqrt_t d_in,
  output tlik_pkg::sqrt_t d_out
);
  import tlik_pkg::*;

  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] t;
  logic            take;

  always_comb begin
    bitv = SQ_W'(1) << {idx, 1'b0};
    t    = d_in.res + bitv;
    take = {1'b0, d_in.v} >= t;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (take) begin
        d_out.v   <= d_in.v - t[SV_W-1:0];
        d_out.res <= (d_in.res >> 1) + bitv;
      end else begin
        d_out.v   <= d_in.v;
        d_out.res <= d_in.res >> 1;
      end
    end
  end

endmodule

// File: src/tlik_vec_cell.sv
// ----------------------------------------------------------------------------
// tlik_vec_cell: one CORDIC vectoring micro-rotation
// Drives y toward zero and accumulates the angle in z.
// ----------------------------------------------------------------------------
module tlik_vec_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    idx,
  input  tlik_pkg::vec_t d_in,
  output tlik_pkg::vec_t d_out
);
  import tlik_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [31:0]          a;

  always_comb begin
    xs = d_in.x >>> idx;
    ys = d_in.y >>> idx;
    a  = atan_lut(idx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.zero <= d_in.zero;
      if (!d_in.y[CW-1]) begin
        d_out.x <= d_in.x + ys;
        d_out.y <= d_in.y - xs;
        d_out.z <= d_in.z + a;
      end else begin
        d_out.x <= d_in.x - ys;
        d_out.y <= d_in.y + xs;
        d_out.z <= d_in.z - a;
      end
    end
  end

endmodule

// File: src/tlik_rot_cell.sv
// ----------------------------------------------------------------------------
// tlik_rot_cell: one CORDIC rotation micro-rotation
// Turns (x, y) by the sign of the residual angle z.
// ----------------------------------------------------------------------------
module tlik_rot_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    idx,
  input  tlik_pkg::rot_t d_in,
  output tlik_pkg::rot_t d_out
);
  import tlik_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [31:0]          a;

  always_comb begin
    xs = d_in.x >>> idx;
    ys = d_in.y >>> idx;
    a  = atan_lut(idx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!d_in.z[31]) begin
        d_out.x <= d_in.x - ys;
        d_out.y <= d_in.y + xs;
        d_out.z <= d_in.z - a;
      end else begin
        d_out.x <= d_in.x + ys;
        d_out.y <= d_in.y - xs;
        d_out.z <= d_in.z + a;
      end
    end
  end

endmodule

// File: src/tlik_checker.sv
// ----------------------------------------------------------------------------
// tlik_checker: port-level checks for the arm solver
// Watches handshake and backpressure behavior seen at the top level.
// ----------------------------------------------------------------------------
module tlik_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // a stalled result request stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  // input stalls only because a finished result is held back
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not caused by output backpressure");

  // pipeline empties on reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // an empty output never stalls the input
  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output");

endmodule

bind two_link_planar_inverse_kinematics tlik_checker u_tlik_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

// File: tb/two_link_planar_inverse_kinematics_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_planar_inverse_kinematics_checker: result predictor and scoreboard
// Watches the target and result channels of the arm solver, computes the
// expected joint angles, elbow point and reach flag for every accepted target
// request and compares each result request with the oldest expectation.
// ----------------------------------------------------------------------------
module two_link_planar_inverse_kinematics_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] shoulder_angle,
  input  logic signed [15:0] elbow_angle,
  input  logic signed [15:0] elbow_x,
  input  logic signed [15:0] elbow_y,
  input  logic               unreachable,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 solved_count,
  output int                 unreach_count
);
  import tlik_pkg::*;

  typedef struct packed {
    logic [15:0] q1;
    logic [15:0] q2;
    logic [15:0] ex;
    logic [15:0] ey;
    logic        unr;
  } pose_t;

  localparam longint Q30 = 64'sd1073741824;
  localparam int      STG = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

  // arctangent table, 32-bit binary angles
  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

  logic [15:0] upper_len, lower_len;
  pose_t       pose_queue[$];

  // vectoring arctangent of (yv, xv); >>> on longint floors like the block
  function automatic logic [31:0] arc_of(longint yv, longint xv);
    longint x, y, t, xs, ys;
    logic [31:0] z;
    x = xv;
    y = yv;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 32'h4000_0000;
      end else begin
        t = x; x = -y; y = t; z = 32'hC000_0000;
      end
    end
    for (int i = 0; i < STG; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b, w;
    r = 0;
    w = v;
    b = 64'sd1 <<< 62;
    while (b > w) b = b >>> 2;
    while (b != 0) begin
      if (w >= r + b) begin
        w = w - (r + b); r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] to_q88(longint v);
    longint r;
    r = (v + (64'sd1 <<< 29)) >>> 30;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic [15:0] round_angle(logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h8000;
    return t[31:16];
  endfunction

  function automatic pose_t solve_arm(logic signed [15:0] tx, logic signed [15:0] ty);
    longint x, y, l1, l2, r2, num, den, c, s, q, ex, ey, t, xs, ys;
    logic [31:0] q1, z;
    pose_t p;
    x = tx;
    y = ty;
    l1 = upper_len;
    l2 = lower_len;
    r2 = x * x + y * y;
    num = l1 * l1 + l2 * l2 - r2;
    den = 2 * l1 * l2;
    p.unr = 1'b0;
    if (den == 0) begin
      c = -Q30;
      p.unr = (r2 != (l1 + l2) * (l1 + l2));
    end else if (num > den) begin
      c = Q30; p.unr = 1'b1;
    end else if (num < -den) begin
      c = -Q30; p.unr = 1'b1;
    end else begin
      q = ((num < 0 ? -num : num) <<< 30) / den;
      c = (num < 0) ? -q : q;
    end
    s = root_floor((64'sd1 <<< 60) - c * c);
    p.q2 = round_angle(arc_of(s, -c));
    q1 = arc_of(y <<< 24, x <<< 24) - arc_of(l2 * s, l1 * Q30 - l2 * c);
    p.q1 = round_angle(q1);
    // rotate (L1/gain, 0) by q1
    z = q1;
    ex = l1 * 64'sd652032875;
    ey = 0;
    if (z > 32'h4000_0000 && z < 32'hC000_0000) begin
      if (!z[31]) begin
        ey = ex; ex = 0; z = z - 32'h4000_0000;
      end else begin
        ey = -ex; ex = 0; z = z + 32'h4000_0000;
      end
    end
    for (int i = 0; i < STG; i++) begin
      xs = ex >>> i;
      ys = ey >>> i;
      if (!z[31]) begin
        t = ex - ys; ey = ey + xs; ex = t; z = z - ATAN_TAB[i];
      end else begin
        t = ex + ys; ey = ey - xs; ex = t; z = z + ATAN_TAB[i];
      end
    end
    p.ex = to_q88(ex);
    p.ey = to_q88(ey);
    return p;
  endfunction

  assign pending = pose_queue.size();

  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      upper_len     <= UPPER_RST;
      lower_len     <= LOWER_RST;
      fail_count    <= 0;
      solved_count  <= 0;
      unreach_count <= 0;
      pose_queue.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        if (cfg_index == REG_UPPER) upper_len <= cfg_data;
        else lower_len <= cfg_data;
      end
      // result request against oldest expectation
      if (out_valid && !out_stall) begin
        if (pose_queue.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = pose_queue.pop_front();
          solved_count <= solved_count + 1;
          if (unreachable) unreach_count <= unreach_count + 1;
          if (shoulder_angle !== e.q1 || elbow_angle !== e.q2 || elbow_x !== e.ex ||
              elbow_y !== e.ey || unreachable !== e.unr) begin
            fail_count <= fail_count + 1;
            if (shoulder_angle !== e.q1)
              $error("shoulder_angle exp %h got %h", e.q1, shoulder_angle);
            if (elbow_angle !== e.q2)
              $error("elbow_angle exp %h got %h", e.q2, elbow_angle);
            if (elbow_x !== e.ex) $error("elbow_x exp %h got %h", e.ex, elbow_x);
            if (elbow_y !== e.ey) $error("elbow_y exp %h got %h", e.ey, elbow_y);
            if (unreachable !== e.unr)
              $error("unreachable exp %b got %b", e.unr, unreachable);
          end
        end
      end
      // target request: predict with current link lengths
      if (in_valid && !in_stall) pose_queue.push_back(solve_arm(target_x, target_y));
    end
  end

endmodule

// File: tb/two_link_planar_inverse_kinematics_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_planar_inverse_kinematics_test: top of the arm solver testbench
// Drives target requests and link length writes over several length settings,
// with random idle bursts on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module two_link_planar_inverse_kinematics_test;
  import tlik_pkg::*;

  localparam int WATCHDOG = 4000;

  logic               clk, rst;
  logic               in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] target_x, target_y;
  logic signed [15:0] shoulder_angle, elbow_angle, elbow_x, elbow_y;
  logic               unreachable;
  logic               cfg_write, cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count, pending, solved_count, unreach_count;
  int                 idle_cycles;
  bit                 calm;
  logic [15:0]        up_len, low_len;

  two_link_planar_inverse_kinematics u_dut (.*);

  two_link_planar_inverse_kinematics_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side stall bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays high across back-to-back requests; dropped only for idling
  task automatic send_target(logic [15:0] x, logic [15:0] y);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    if (!in_valid) in_valid <= 1'b1;
    target_x <= x;
    target_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait for drain, then past pipeline depth before touching lengths
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  task automatic set_lengths(logic [15:0] l1, logic [15:0] l2);
    drain();
    cfg_write <= 1'b1; cfg_index <= REG_UPPER; cfg_data <= l1;
    @(posedge clk);
    cfg_index <= REG_LOWER; cfg_data <= l2;
    @(posedge clk);
    cfg_write <= 1'b0;
    up_len = l1;
    low_len = l2;
  endtask

  // mostly points near the reachable annulus, some wide noise
  task automatic random_target;
    int r, a;
    real ang;
    if ($urandom_range(0, 3) == 0) begin
      send_target(16'($urandom), 16'($urandom));
    end else begin
      r = up_len + low_len;
      a = (up_len > low_len) ? up_len - low_len : low_len - up_len;
      r = $urandom_range(a, r + 64);
      if (r > 32767) r = 32767;
      ang = $urandom_range(0, 6283) / 1000.0;
      send_target(16'($rtoi(r * $cos(ang))), 16'($rtoi(r * $sin(ang))));
    end
  endtask

  initial begin
    logic [15:0] dx [12] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF,
                             16'h8000, 16'h2800, 16'hD800, 16'h0001, 16'h0F00, 16'hFFFF};
    logic [15:0] dy [12] = '{16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF,
                             16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h1900, 16'hFFFF};
    in_valid = 1'b0; target_x = '0; target_y = '0;
    cfg_write = 1'b0; cfg_index = REG_UPPER; cfg_data = '0;
    calm = 1'b0;
    up_len = UPPER_RST; low_len = LOWER_RST;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, zero vector, straight, folded, too near, too far
    foreach (dx[i]) send_target(dx[i], dy[i]);
    set_lengths(16'd0, 16'd1280);
    send_target(16'h0500, 16'h0000);
    send_target(16'h0000, 16'h0000);
    send_target(16'h0100, 16'h0300);
    set_lengths(16'hFFFF, 16'hFFFF);
    send_target(16'h7FFF, 16'h7FFF);
    send_target(16'h8000, 16'h0001);
    send_target(16'h0000, 16'h0000);
    set_lengths(16'd2560, 16'd2560);
    send_target(16'h0000, 16'h0000);
    send_target(16'h1400, 16'h0000);
    // random phases over several length settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_lengths(UPPER_RST, LOWER_RST);
        1: set_lengths(16'($urandom_range(1, 12000)), 16'($urandom_range(1, 12000)));
        2: set_lengths(16'd1, 16'($urandom_range(100, 20000)));
        3: set_lengths(16'($urandom_range(20000, 65535)), 16'($urandom_range(0, 65535)));
        4: set_lengths(16'($urandom), 16'($urandom));
        default: set_lengths(16'($urandom_range(500, 9000)), 16'($urandom_range(500, 9000)));
      endcase
      if (ph == 5) calm = 1'b1;
      for (int k = 0; k < 120; k++) random_target();
      if (ph == 2) drain();
    end
    drain();
    $display("ran %0d targets over 10 link settings, %0d flagged out of reach",
             solved_count, unreach_count);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
